// ===== hdl/vmag_pkg.sv =====
// shared types and constants for the vector magnitude block
// no dependencies; imported by the controller, the datapath and the top level
package vmag_pkg;

  // field widths of the transaction payloads
  localparam int IN_WIDTH   = 16;
  localparam int MAG_WIDTH  = 16;

  // component width taken from each input field (sign at bit COMP_WIDTH-1)
  localparam int COMP_WIDTH = 16;
  localparam int NUM_COMP   = 3;
  localparam int SEL_WIDTH  = $clog2(NUM_COMP);

  // squared sums and square root widths
  localparam int SQ_WIDTH   = 2 * COMP_WIDTH;
  localparam int SUM_WIDTH  = SQ_WIDTH + 2;
  localparam int ROOT_BITS  = SUM_WIDTH / 2;
  localparam int REM_WIDTH  = ROOT_BITS + 2;
  localparam int CNT_WIDTH  = $clog2(ROOT_BITS);

  // input transaction
  typedef struct packed {
    logic signed [IN_WIDTH-1:0] comp_x;
    logic signed [IN_WIDTH-1:0] comp_y;
    logic signed [IN_WIDTH-1:0] comp_z;
    logic                       last_of_field;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [MAG_WIDTH-1:0] magnitude;
    logic [MAG_WIDTH-1:0] range_min;
    logic [MAG_WIDTH-1:0] range_max;
  } out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic                 load;
    logic                 square;
    logic [SEL_WIDTH-1:0] sel;
    logic                 root_step;
    logic                 finish;
  } cmd_t;

endpackage

// ===== hdl/vmag_datapath.sv =====
// datapath: component magnitudes, shared squarer, bit-serial square root,
// running range and output register; uses vmag_pkg
module vmag_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vmag_pkg::cmd_t cmd_i,
  input  vmag_pkg::in_t  in_data_i,
  output vmag_pkg::out_t out_data_o
);
  import vmag_pkg::*;

  logic [COMP_WIDTH-1:0] abs_q [NUM_COMP];
  logic [COMP_WIDTH-1:0] abs_d [NUM_COMP];
  logic [COMP_WIDTH-1:0] comp_raw [NUM_COMP];
  logic                  last_q;
  logic [SUM_WIDTH-1:0]  sum_q, sum_d;
  logic [REM_WIDTH-1:0]  rem_q, rem_d;
  logic [ROOT_BITS-1:0]  root_q, root_d;
  logic [SQ_WIDTH-1:0]   prod;
  logic [REM_WIDTH-1:0]  rem_sh, trial;
  logic [MAG_WIDTH-1:0]  mag;
  logic [MAG_WIDTH-1:0]  min_q, min_d, max_q, max_d;
  logic                  started_q, started_d;
  out_t                  out_q;

  // absolute value of each component, taken from its low COMP_WIDTH bits
  assign comp_raw[0] = COMP_WIDTH'(in_data_i.comp_x);
  assign comp_raw[1] = COMP_WIDTH'(in_data_i.comp_y);
  assign comp_raw[2] = COMP_WIDTH'(in_data_i.comp_z);

  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      abs_d[i] = comp_raw[i][COMP_WIDTH-1] ? (~comp_raw[i] + 1'b1) : comp_raw[i];
    end
  end

  // one square per cycle into the running sum
  assign prod = SQ_WIDTH'(abs_q[cmd_i.sel]) * SQ_WIDTH'(abs_q[cmd_i.sel]);

  // one root bit per cycle, two radicand bits shifted in from the top of the sum
  assign rem_sh = {rem_q[REM_WIDTH-3:0], sum_q[SUM_WIDTH-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_comb begin
    sum_d  = sum_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (cmd_i.load) begin
      sum_d  = '0;
      rem_d  = '0;
      root_d = '0;
    end else if (cmd_i.square) begin
      sum_d = sum_q + SUM_WIDTH'(prod);
    end else if (cmd_i.root_step) begin
      sum_d = sum_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  // running range of the current field
  assign mag = MAG_WIDTH'(root_q);

  always_comb begin
    min_d     = min_q;
    max_d     = max_q;
    started_d = started_q;
    if (cmd_i.finish) begin
      if (!started_q) begin
        min_d = mag;
        max_d = mag;
      end else begin
        if (mag < min_q) min_d = mag;
        if (mag > max_q) max_d = mag;
      end
      started_d = !last_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      abs_q  <= abs_d;
      last_q <= in_data_i.last_of_field;
    end
    sum_q  <= sum_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    if (cmd_i.finish) begin
      out_q.magnitude <= mag;
      out_q.range_min <= min_d;
      out_q.range_max <= max_d;
    end
  end

  // range state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= '0;
      max_q     <= '0;
      started_q <= 1'b0;
    end else begin
      min_q     <= min_d;
      max_q     <= max_d;
      started_q <= started_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hdl/vmag_ctrl.sv =====
// controller: sequences load, squaring, root steps and result hand-off
// uses vmag_pkg for the command struct and the step counts
module vmag_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vmag_pkg::cmd_t cmd_o
);
  import vmag_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_FINISH
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 in_fire, out_fire, slot_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign slot_free  = !out_valid_q || out_ready_i;

  // commands and next state
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        cmd_o.sel    = SEL_WIDTH'(cnt_q);
        if (cnt_q == CNT_WIDTH'(NUM_COMP - 1)) begin
          cnt_d   = '0;
          state_d = ST_ROOT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == CNT_WIDTH'(ROOT_BITS - 1)) begin
          cnt_d   = '0;
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FINISH: begin
        // wait until the output register is free
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state, counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // at most one datapath command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.square, cmd_o.root_step, cmd_o.finish}))
    else $error("vmag_ctrl: more than one datapath command");

  // a new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("vmag_ctrl: result overwritten");

  // an accepted transaction always starts the squaring phase from step zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_SQUARE) && (cnt_q == '0))
    else $error("vmag_ctrl: squaring did not start");

  // the root phase moves to the finish state after its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) && (cnt_q == CNT_WIDTH'(ROOT_BITS - 1)) |=> state_q == ST_FINISH)
    else $error("vmag_ctrl: root phase length wrong");

endmodule

// ===== hdl/vector_magnitude_with_range.sv =====
// channel  | direction | handshake             | payload
// input    | in        | in_valid_i/in_ready_o | in_data_i  (vmag_pkg::in_t)
// output   | out       | out_valid_o/out_ready_i | out_data_o (vmag_pkg::out_t)
//
// one transaction in, one result out; each transaction is finished before the next is taken,
// with the square root resolving one bit per cycle
// after three squares through a single shared multiplier
// rst_ni clears the controller and the running range; the first item starts a field
// a new transaction is taken while a finished result waits; the next result is held
// back in the controller until the output register is taken
// top level: joins vmag_ctrl and vmag_datapath, uses vmag_pkg
module vector_magnitude_with_range (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vmag_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vmag_pkg::out_t out_data_o
);
  import vmag_pkg::*;

  cmd_t cmd;

  // sequencing
  vmag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // arithmetic and range
  vmag_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
